/* rtl/srsi_pkg.sv */
// shared widths, constants and types for the simpson square integral block
package srsi_pkg;

  localparam int BOUND_W       = 16;               // signed q8.8 bounds
  localparam int CNT_W         = 9;                // interval count
  localparam int AREA_W        = 40;               // result, 16 fraction bits
  localparam int MAX_INTERVALS = 256;              // room for MAX_INTERVALS + 1 points
  localparam int SQ_W          = 2 * BOUND_W;      // square of a bound
  localparam int CUBE_W        = 3 * BOUND_W;      // cube of a bound, signed
  localparam int MAG_W         = CUBE_W - 1;       // magnitude of the cube difference
  localparam int DIV_SHIFT     = 8;                // 768 = 3 * 2^8
  localparam int DIV_W         = MAG_W - DIV_SHIFT;
  localparam int DIV_CNT_W     = $clog2(DIV_W + 1);

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  // status of the divide-by-three unit
  typedef struct packed {
    logic busy;
    logic done;
  } srsi_div_st_t;

endpackage

/* rtl/srsi_if.sv */
// valid/ready channel interfaces for input and result beats
interface srsi_in_if;
  import srsi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [BOUND_W-1:0] lower_bound;
  logic signed [BOUND_W-1:0] upper_bound;
  logic        [CNT_W-1:0]   intervals;

  modport source (output valid, output lower_bound, output upper_bound,
                  output intervals, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound,
                  input intervals, output ready);
endinterface

interface srsi_out_if;
  import srsi_pkg::*;

  logic              valid;
  logic              ready;
  logic [AREA_W-1:0] area;
  logic              bad_count;
  logic              clipped;

  modport source (output valid, output area, output bad_count, output clipped,
                  input ready);
  modport sink   (input valid, input area, input bad_count, input clipped,
                  output ready);
endinterface

/* rtl/srsi_div3.sv */
// divide by three on one small reciprocal multiplier
module srsi_div3 (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [srsi_pkg::DIV_W-1:0]   dividend,
  output logic [srsi_pkg::DIV_W-1:0]   quotient,
  output srsi_pkg::srsi_div_st_t       status
);
  import srsi_pkg::*;

  localparam int LO_W   = 20;              // 2^20 is one more than a multiple of three
  localparam int HI_W   = DIV_W - LO_W;
  localparam int SUM_W  = LO_W + 1;
  localparam int PROD_W = SUM_W + LO_W;
  localparam logic [LO_W-1:0] SPLIT_THIRD = LO_W'(349525);  // (2^20 - 1) / 3
  localparam logic [LO_W-1:0] RECIP_3     = LO_W'(699051);  // (2^21 + 1) / 3, exact below 2^21

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SPLIT,
    PH_RECIP,
    PH_SUM
  } phase_t;

  phase_t              phase_r;
  logic [DIV_W-1:0]    x_r;
  logic [2*HI_W-1:0]   hp_r;
  logic [SUM_W-1:0]    s_r;
  logic [LO_W-1:0]     q2_r;
  logic [DIV_W-1:0]    quo_r;
  logic                done_r;
  logic [HI_W-1:0]     x_hi;
  logic [LO_W-1:0]     x_lo;
  logic [SUM_W-1:0]    mul_x;
  logic [LO_W-1:0]     mul_c;
  logic [PROD_W-1:0]   prod;

  assign x_hi = x_r[DIV_W-1:LO_W];
  assign x_lo = x_r[LO_W-1:0];

  // x = hi * 2^20 + lo, so x / 3 = hi * (2^20 - 1) / 3 + (hi + lo) / 3
  always_comb begin
    mul_x = (phase_r == PH_SPLIT) ? SUM_W'(x_hi) : s_r;
    mul_c = (phase_r == PH_SPLIT) ? SPLIT_THIRD : RECIP_3;
    prod  = PROD_W'(mul_x) * PROD_W'(mul_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == PH_SUM);
      unique case (phase_r)
        PH_IDLE: begin
          if (start) begin
            x_r     <= dividend;
            phase_r <= PH_SPLIT;
          end
        end
        PH_SPLIT: begin
          hp_r    <= prod[2*HI_W-1:0];
          s_r     <= SUM_W'(x_hi) + SUM_W'(x_lo);
          phase_r <= PH_RECIP;
        end
        PH_RECIP: begin
          q2_r    <= prod[PROD_W-1:SUM_W];
          phase_r <= PH_SUM;
        end
        PH_SUM: begin
          quo_r   <= DIV_W'(hp_r) + DIV_W'(q2_r);
          phase_r <= PH_IDLE;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  assign quotient    = quo_r;
  assign status.busy = (phase_r != PH_IDLE);
  assign status.done = done_r;

endmodule

/* rtl/simpson_rule_square_integral.sv */
// top level: composite simpson integral of x squared in fixed point
//
// channels: in_ch carries lower_bound, upper_bound (signed q8.8) and
// intervals; out_ch returns area (unsigned, 16 fraction bits, truncated),
// bad_count and clipped. a beat moves on a clock edge with valid and ready high.
// simpson's rule is exact for x squared, so the weighted sum reduces to
// |B^3 - A^3| / 768 on the raw bounds: one shared 32x16 multiplier forms both
// cubes in turn, the sub state hands the difference to the divider, then the
// divide by three runs on a small reciprocal multiplier.
// a rejected count (zero, odd or above the point budget) skips the arithmetic.
// one item at a time: in_ch.ready is high only while the sequencer is idle,
// so no new beat is taken until the last result reaches the output register.
// the result sits in an output register; a new input beat is taken while
// it waits, but a finished result is held until the receiver takes the
// pending one, so a stalled receiver stalls the block after one item.
// reset (synchronous, active low) returns to idle with no result pending.
module simpson_rule_square_integral (
  input  logic       clk,
  input  logic       rst_n,
  srsi_in_if.sink    in_ch,
  srsi_out_if.source out_ch
);
  import srsi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r;
  logic [1:0] step_r;               // multiplier step: lo^2, lo^3, hi^2, hi^3

  // operands and intermediate products
  logic signed [BOUND_W-1:0] lo_r;
  logic signed [BOUND_W-1:0] hi_r;
  logic signed [SQ_W-1:0]    sq_r;
  logic signed [CUBE_W-1:0]  lo3_r;
  logic signed [CUBE_W-1:0]  hi3_r;

  // finished result waiting for the output register
  logic [AREA_W-1:0] res_area_r;
  logic              res_bad_r;
  logic              res_clip_r;

  // output register
  logic              out_valid_r;
  logic [AREA_W-1:0] out_area_r;
  logic              out_bad_r;
  logic              out_clip_r;

  logic                      in_fire;
  logic                      out_fire;
  logic                      out_load;
  logic                      cnt_bad;
  logic signed [BOUND_W-1:0] mul_op;
  logic signed [SQ_W-1:0]    mul_a;
  logic signed [CUBE_W-1:0]  prod;
  logic signed [CUBE_W-1:0]  diff;
  logic [MAG_W-1:0]          mag;
  logic                      div_start;
  logic [DIV_W-1:0]          div_quo;
  srsi_div_st_t              div_st;
  logic [AREA_W:0]           area_ext;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // hand over once the output register is free or being emptied
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // count must be even, nonzero and within the sample point budget
  assign cnt_bad = (in_ch.intervals == '0) || in_ch.intervals[0] ||
                   (in_ch.intervals > CNT_W'(MAX_INTERVALS));

  // shared multiplier: odd steps reuse the square just formed
  always_comb begin
    mul_op = step_r[1] ? hi_r : lo_r;
    mul_a  = step_r[0] ? sq_r : {{(SQ_W - BOUND_W){mul_op[BOUND_W-1]}}, mul_op};
    prod   = mul_a * mul_op;
  end

  // magnitude of the cube difference, the 2^8 of 768 taken as a shift
  always_comb begin
    diff = hi3_r - lo3_r;
    mag  = diff[CUBE_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
  end

  assign div_start = (state_r == ST_SUB);

  srsi_div3 u_div3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag[MAG_W-1:DIV_SHIFT]),
    .quotient (div_quo),
    .status   (div_st)
  );

  // saturation check on the quotient
  assign area_ext = (AREA_W + 1)'(div_quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            lo_r   <= in_ch.lower_bound;
            hi_r   <= in_ch.upper_bound;
            step_r <= '0;
            if (cnt_bad) begin
              res_area_r <= '0;
              res_bad_r  <= 1'b1;
              res_clip_r <= 1'b0;
              state_r    <= ST_DONE;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          step_r <= step_r + 1'b1;
          unique case (step_r)
            2'd0, 2'd2: sq_r  <= prod[SQ_W-1:0];
            2'd1:       lo3_r <= prod;
            2'd3: begin
              hi3_r   <= prod;
              state_r <= ST_SUB;
            end
            default: ;
          endcase
        end
        ST_SUB: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_st.done) begin
            res_clip_r <= area_ext[AREA_W];
            res_area_r <= area_ext[AREA_W] ? AREA_MAX : area_ext[AREA_W-1:0];
            res_bad_r  <= 1'b0;
            state_r    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_area_r <= res_area_r;
            out_bad_r  <= res_bad_r;
            out_clip_r <= res_clip_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.area      = out_area_r;
  assign out_ch.bad_count = out_bad_r;
  assign out_ch.clipped   = out_clip_r;

`ifndef NO_ASSERTIONS
  // the divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // no new item is taken while the divider is still working
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_st.busy)
    else $error("input ready while divider busy");

  // a rejected count always reports zero area and no saturation
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_area_r == '0) && !out_clip_r)
    else $error("rejected count with nonzero result");

  // after an accepted beat the block is busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input ready straight after accepting a beat");
`endif

endmodule
